// ===== rtl/fse_pkg.sv =====
package fse_pkg;

  localparam int CHAR_W = 8;
  localparam int ARG_W = 32;
  localparam int COUNT_W = 8;
  localparam int DIGITS = 10;
  localparam int IDX_W = 4;
  localparam int NIB_IDX_W = 3;
  localparam int OUTPUT_BUFFER_BYTES_DEF = 256;

  // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n
  localparam logic [ARG_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PCT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LD = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LX = 8'h78;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_NUL,
    KIND_DEC,
    KIND_HEX
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  negate;
    kind_e kind;
    logic  div_step;
    logic  emit;
    logic  emit_pre;
    logic  pre_pct;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_pct;
    logic is_d;
    logic is_x;
    logic arg_neg;
    logic div_done;
    logic body_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/fse_in_if.sv =====
interface fse_in_if;
  logic                         valid;
  logic                         ready;
  logic [fse_pkg::CHAR_W-1:0]   fmt_char;
  logic [fse_pkg::ARG_W-1:0]    arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink (input valid, input fmt_char, input arg_value, output ready);
endinterface

// ===== rtl/fse_out_if.sv =====
interface fse_out_if;
  logic                         valid;
  logic                         ready;
  logic [fse_pkg::CHAR_W-1:0]   out_char;
  logic                         out_last;
  logic [fse_pkg::COUNT_W-1:0]  out_count;

  modport source (output valid, output out_char, output out_last, output out_count,
                  input ready);
  modport sink (input valid, input out_char, input out_last, input out_count,
                output ready);
endinterface

// ===== rtl/fse_ctrl.sv =====
module fse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fse_pkg::sts_t sts_i,
  output fse_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PRE  = 2'd2;
  localparam logic [1:0] S_BODY = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                pending_q, pending_d;
  logic                pre_q, pre_d;
  logic                pre_pct_q, pre_pct_d;
  fse_pkg::kind_e      kind_q, kind_d;

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    pre_d       = pre_q;
    pre_pct_d   = pre_pct_q;
    kind_d      = kind_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pre_d      = 1'b0;
          pre_pct_d  = 1'b1;
          kind_d     = fse_pkg::KIND_CHAR;
          if (sts_i.is_nul) begin
            // a lone percent before the terminator comes out first
            kind_d    = fse_pkg::KIND_NUL;
            pre_d     = pending_q;
            pending_d = 1'b0;
            state_d   = pending_q ? S_PRE : S_BODY;
          end else if (!pending_q) begin
            if (sts_i.is_pct) begin
              pending_d = 1'b1;
            end else begin
              state_d = S_BODY;
            end
          end else begin
            pending_d = 1'b0;
            if (sts_i.is_d) begin
              kind_d       = fse_pkg::KIND_DEC;
              cmd_o.negate = sts_i.arg_neg;
              pre_d        = sts_i.arg_neg;
              pre_pct_d    = 1'b0;
              state_d      = S_DIV;
            end else if (sts_i.is_x) begin
              kind_d  = fse_pkg::KIND_HEX;
              state_d = S_BODY;
            end else if (sts_i.is_pct) begin
              state_d = S_BODY;
            end else begin
              pre_d   = 1'b1;
              state_d = S_PRE;
            end
          end
          cmd_o.kind = kind_d;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = pre_q ? S_PRE : S_BODY;
        end
      end
      S_PRE: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_pre = 1'b1;
          cmd_o.pre_pct  = pre_pct_q;
          state_d        = S_BODY;
        end
      end
      S_BODY: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.body_last;
          if (sts_i.body_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pending_q <= 1'b0;
      pre_q     <= 1'b0;
      pre_pct_q <= 1'b0;
      kind_q    <= fse_pkg::KIND_CHAR;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      pre_q     <= pre_d;
      pre_pct_q <= pre_pct_d;
      kind_q    <= kind_d;
    end
  end

endmodule

// ===== rtl/fse_datapath.sv =====
module fse_datapath #(
  parameter int OUTPUT_BUFFER_BYTES = fse_pkg::OUTPUT_BUFFER_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fse_pkg::CHAR_W-1:0]   in_fmt_char_i,
  input  logic [fse_pkg::ARG_W-1:0]    in_arg_value_i,
  input  logic                         out_ready_i,
  input  fse_pkg::cmd_t                cmd_i,
  output fse_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  output logic [fse_pkg::CHAR_W-1:0]   out_char_o,
  output logic                         out_last_o,
  output logic [fse_pkg::COUNT_W-1:0]  out_count_o
);

  localparam int CountCap = (OUTPUT_BUFFER_BYTES - 1 > 255) ? 255 : OUTPUT_BUFFER_BYTES - 1;
  localparam int ProdW = 2 * fse_pkg::ARG_W;

  logic [fse_pkg::CHAR_W-1:0]   char_q;
  logic [fse_pkg::ARG_W-1:0]    mag_q;
  logic [fse_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [3:0]                   digit_q [fse_pkg::DIGITS];
  logic [fse_pkg::COUNT_W-1:0]  count_q, count_d, count_inc;
  logic                         out_valid_q, out_valid_d;
  logic [fse_pkg::CHAR_W-1:0]   out_char_q;
  logic                         out_last_q;
  logic [fse_pkg::COUNT_W-1:0]  out_count_q;

  logic [ProdW-1:0]             prod;
  logic [fse_pkg::ARG_W-1:0]    quot;
  logic [fse_pkg::ARG_W-1:0]    rem;
  logic [fse_pkg::NIB_IDX_W-1:0] hex_top;
  logic [fse_pkg::IDX_W-1:0]    dig_rd_idx;
  logic [3:0]                   nibble;
  logic [fse_pkg::CHAR_W-1:0]   body_char;
  logic [fse_pkg::CHAR_W-1:0]   emit_char;
  logic                         body_emit;

  // one decimal digit per step: reciprocal multiply, remainder by shift-add
  assign prod = ProdW'(mag_q) * ProdW'(fse_pkg::DIV10_RECIP);
  assign quot = fse_pkg::ARG_W'(prod >> fse_pkg::DIV10_SHIFT);
  assign rem  = mag_q - ((quot << 3) + (quot << 1));

  // most significant nonzero nibble of the incoming word
  always_comb begin
    hex_top = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_arg_value_i[4*i +: 4] != 4'h0) begin
        hex_top = fse_pkg::NIB_IDX_W'(i);
      end
    end
  end

  assign dig_rd_idx = idx_q - fse_pkg::IDX_W'(1);
  assign nibble = 4'(mag_q >> {idx_q[fse_pkg::NIB_IDX_W-1:0], 2'b00});

  always_comb begin
    case (cmd_i.kind)
      fse_pkg::KIND_NUL: body_char = fse_pkg::CH_NUL;
      fse_pkg::KIND_DEC: body_char = fse_pkg::CH_ZERO + {4'h0, digit_q[dig_rd_idx]};
      fse_pkg::KIND_HEX: begin
        if (nibble < 4'd10) begin
          body_char = fse_pkg::CH_ZERO + {4'h0, nibble};
        end else begin
          body_char = fse_pkg::CH_LA + {4'h0, nibble} - 8'd10;
        end
      end
      default: body_char = char_q;
    endcase
  end

  assign emit_char = cmd_i.emit_pre ? (cmd_i.pre_pct ? fse_pkg::CH_PCT : fse_pkg::CH_MINUS)
                                    : body_char;
  assign body_emit = cmd_i.emit && !cmd_i.emit_pre;
  assign count_inc = (count_q < fse_pkg::COUNT_W'(CountCap)) ? count_q + 8'd1 : count_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (cmd_i.kind == fse_pkg::KIND_HEX) ? {1'b0, hex_top} : '0;
    end else if (cmd_i.div_step) begin
      idx_d = idx_q + fse_pkg::IDX_W'(1);
    end else if (body_emit && (cmd_i.kind == fse_pkg::KIND_DEC ||
                               cmd_i.kind == fse_pkg::KIND_HEX)) begin
      idx_d = idx_q - fse_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.emit) begin
      if (body_emit && cmd_i.kind == fse_pkg::KIND_NUL) begin
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= in_fmt_char_i;
      mag_q  <= cmd_i.negate ? (fse_pkg::ARG_W'(0) - in_arg_value_i) : in_arg_value_i;
    end else if (cmd_i.div_step) begin
      mag_q <= quot;
    end
    if (cmd_i.div_step) begin
      digit_q[idx_q] <= rem[3:0];
    end
    if (cmd_i.emit) begin
      out_char_q  <= emit_char;
      out_last_q  <= cmd_i.last;
      // the terminator carries the final count and is not counted itself
      out_count_q <= (body_emit && cmd_i.kind == fse_pkg::KIND_NUL) ? count_q : count_inc;
    end
  end

  always_comb begin
    sts_o.is_nul   = (in_fmt_char_i == fse_pkg::CH_NUL);
    sts_o.is_pct   = (in_fmt_char_i == fse_pkg::CH_PCT);
    sts_o.is_d     = (in_fmt_char_i == fse_pkg::CH_LD);
    sts_o.is_x     = (in_fmt_char_i == fse_pkg::CH_LX);
    sts_o.arg_neg  = in_arg_value_i[fse_pkg::ARG_W-1];
    sts_o.div_done = (quot == '0) ||
                     (idx_q == fse_pkg::IDX_W'(fse_pkg::DIGITS - 1));
    sts_o.out_free = !out_valid_q || out_ready_i;
    case (cmd_i.kind)
      fse_pkg::KIND_DEC: sts_o.body_last = (idx_q == fse_pkg::IDX_W'(1));
      fse_pkg::KIND_HEX: sts_o.body_last = (idx_q == '0);
      default:           sts_o.body_last = 1'b1;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_count_o = out_count_q;

endmodule

// ===== rtl/format_string_engine.sv =====
// a literal byte is held in char_q after its transfer and moves to the output register
// once that register is free; %d first makes one decimal digit per division step (up to
// 10, one reciprocal multiply each), then emits its bytes; other directives emit directly
// a new item is taken only after the last byte of the previous item has been emitted,
// but while that last result still waits in the output register
// reset: asynchronous active low, clears the percent flag, the count and the sequencer
module format_string_engine #(
  parameter int OUTPUT_BUFFER_BYTES = fse_pkg::OUTPUT_BUFFER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fse_in_if.sink    in_i,
  fse_out_if.source out_o
);

  fse_pkg::cmd_t cmd;
  fse_pkg::sts_t sts;

  fse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fse_datapath #(
    .OUTPUT_BUFFER_BYTES (OUTPUT_BUFFER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fmt_char_i  (in_i.fmt_char),
    .in_arg_value_i (in_i.arg_value),
    .out_ready_i    (out_o.ready),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_char_o     (out_o.out_char),
    .out_last_o     (out_o.out_last),
    .out_count_o    (out_o.out_count)
  );

endmodule
